### src/tsd_pkg.sv
package tsd_pkg;

   // packet size limit, in dwords
   localparam int MAX_PACKET_DWORDS = 256;
   localparam int CNT_W             = $clog2(MAX_PACKET_DWORDS);
   localparam int MIN_DWORDS        = 3;

   // status patterns
   localparam logic [31:0] PAT_DATA  = 32'h7703_0000;
   localparam logic [31:0] MASK_DATA = 32'hff03_0000;
   localparam logic [31:0] PAT_LAST  = 32'h7707_0000;
   localparam logic [31:0] MASK_LAST = 32'hff07_0000;

   // group queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      EV_DWORD    = 2'd0,
      EV_SHORT    = 2'd1,
      EV_OVERFLOW = 2'd2
   } ev_type;

   // results caused by one input word: n words, last/ev apply to the final one
   typedef struct packed {
      logic [1:0]       n;
      logic [2:0][31:0] dw;
      logic             last;
      ev_type           ev;
   } grp_type;

endpackage

### src/tsd_front.sv
module tsd_front import tsd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_data_word,
   input  logic [31:0] req_status_word,
   output logic        push,
   output grp_type     push_grp
);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0]      held_first_ff, held_first_in;
   logic [31:0]      held_second_ff, held_second_in;
   logic             discarding_ff, discarding_in;

   logic             accept;
   logic             is_data;
   logic             is_last;
   logic [CNT_W:0]   cnt_next;
   grp_type          grp;

   assign accept   = req_valid && req_ready;
   assign is_data  = (req_status_word & MASK_DATA) == PAT_DATA;
   assign is_last  = (req_status_word & MASK_LAST) == PAT_LAST;
   assign cnt_next = {1'b0, count_ff} + (CNT_W+1)'(1);

   // classify the word and build its result group
   always_comb begin
      grp            = '0;
      grp.ev         = EV_DWORD;
      count_in       = count_ff;
      held_first_in  = held_first_ff;
      held_second_in = held_second_ff;
      discarding_in  = discarding_ff;
      if (is_data) begin
         if (discarding_ff) begin
            if (is_last) begin
               discarding_in = 1'b0;
            end
         end else if (cnt_next >= (CNT_W+1)'(MAX_PACKET_DWORDS)) begin
            grp.n         = 2'd1;
            grp.ev        = EV_OVERFLOW;
            count_in      = '0;
            discarding_in = !is_last;
         end else begin
            count_in = cnt_next[CNT_W-1:0];
            if (cnt_next == (CNT_W+1)'(1)) begin
               held_first_in = req_data_word;
            end else if (cnt_next == (CNT_W+1)'(2)) begin
               held_second_in = req_data_word;
            end else if (cnt_next == (CNT_W+1)'(MIN_DWORDS)) begin
               grp.n     = 2'd3;
               grp.dw[0] = held_first_ff;
               grp.dw[1] = held_second_ff;
               grp.dw[2] = req_data_word;
               grp.last  = is_last;
            end else begin
               grp.n     = 2'd1;
               grp.dw[0] = req_data_word;
               grp.last  = is_last;
            end
            if (is_last) begin
               // short frame: nothing was passed on yet
               if (cnt_next < (CNT_W+1)'(MIN_DWORDS)) begin
                  grp.n  = 2'd1;
                  grp.ev = EV_SHORT;
               end
               count_in = '0;
            end
         end
      end
   end

   assign push     = accept && (grp.n != 2'd0);
   assign push_grp = grp;

   // packet state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         discarding_ff <= 1'b0;
      end else if (accept) begin
         count_ff      <= count_in;
         discarding_ff <= discarding_in;
      end
   end

   // held dwords
   always_ff @(posedge clock) begin
      if (accept) begin
         held_first_ff  <= held_first_in;
         held_second_ff <= held_second_in;
      end
   end

endmodule

### src/tsd_queue.sv
module tsd_queue import tsd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  grp_type push_grp,
   output logic    not_full,
   input  logic    pop,
   output logic    head_valid,
   output grp_type head_grp
);

   grp_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   fill_ff, fill_in;

   assign not_full   = fill_ff != (QPTR_W+1)'(QUEUE_DEPTH);
   assign head_valid = fill_ff != '0;
   assign head_grp   = mem_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_grp;
      end
   end

endmodule

### src/tsd_back.sv
module tsd_back import tsd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  grp_type     head_grp,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_tlp_dword,
   output logic        rsp_last_of_tlp,
   output logic [1:0]  rsp_event_code
);

   logic [1:0]  sub_ff, sub_in;
   logic        valid_ff, valid_in;
   logic [31:0] dword_ff, dword_in;
   logic        last_ff, last_in;
   ev_type      ev_ff, ev_in;

   logic        load;
   logic        emit;
   logic        is_final;

   assign load     = !valid_ff || rsp_ready;
   assign emit     = load && head_valid;
   assign is_final = sub_ff == (head_grp.n - 2'd1);
   assign pop      = emit && is_final;

   // walk through the words of the head group
   always_comb begin
      sub_in   = sub_ff;
      valid_in = valid_ff;
      dword_in = dword_ff;
      last_in  = last_ff;
      ev_in    = ev_ff;
      if (load) begin
         valid_in = head_valid;
      end
      if (emit) begin
         sub_in   = is_final ? 2'd0 : sub_ff + 2'd1;
         dword_in = head_grp.dw[sub_ff];
         last_in  = is_final && head_grp.last;
         ev_in    = is_final ? head_grp.ev : EV_DWORD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         sub_ff   <= sub_in;
         valid_ff <= valid_in;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      dword_ff <= dword_in;
      last_ff  <= last_in;
      ev_ff    <= ev_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_tlp_dword   = dword_ff;
   assign rsp_last_of_tlp = last_ff;
   assign rsp_event_code  = ev_ff;

endmodule

### src/tlp_rx_status_deframer.sv
// Results pass the group queue, then the output register. One link word per
// cycle is taken while the queue has room; results leave at one word per cycle
// while rsp_ready is high, set by the single output register draining a 4-group
// queue. A third packet dword releases three words, so input can stall briefly.
// Reset (synchronous, active high) clears packet count, discard flag and queue.
module tlp_rx_status_deframer import tsd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_data_word,
   input  logic [31:0] req_status_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_tlp_dword,
   output logic        rsp_last_of_tlp,
   output logic [1:0]  rsp_event_code
);

   logic    push;
   grp_type push_grp;
   logic    pop;
   logic    head_valid;
   grp_type head_grp;

   tsd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_word   (req_data_word),
      .req_status_word (req_status_word),
      .push            (push),
      .push_grp        (push_grp)
   );

   tsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_grp   (push_grp),
      .not_full   (req_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_grp   (head_grp)
   );

   tsd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_grp        (head_grp),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_tlp_dword   (rsp_tlp_dword),
      .rsp_last_of_tlp (rsp_last_of_tlp),
      .rsp_event_code  (rsp_event_code)
   );

endmodule

### tb/tlp_rx_status_deframer_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the deframer, predicts the result words of every
// accepted link word and compares them in order.
module tlp_rx_status_deframer_checker import tsd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_data_word,
   input  logic [31:0] req_status_word,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_tlp_dword,
   input  logic        rsp_last_of_tlp,
   input  logic [1:0]  rsp_event_code,
   output int          fail_count,
   output int          pending_count,
   output int          checked_count
);

   typedef struct packed {
      logic [31:0] dword;
      logic        last;
      ev_type      ev;
   } tlp_word_type;

   // predicted result words, oldest first
   tlp_word_type outgoing_words[$];

   // deframer state as predicted
   int          packet_len;
   logic [31:0] held_first;
   logic [31:0] held_second;
   logic        discarding;

   initial begin
      fail_count    = 0;
      pending_count = 0;
      checked_count = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch @%0t: %s", $time, msg);
      fail_count++;
   endtask

   // advance the predicted state by one accepted link word
   task automatic deframe_word(input logic [31:0] data, input logic [31:0] status);
      logic is_data;
      logic is_last;
      is_data = (status & MASK_DATA) == PAT_DATA;
      is_last = (status & MASK_LAST) == PAT_LAST;
      if (!is_data) return;
      // rest of an overflowed packet is dropped up to its last marker
      if (discarding) begin
         if (is_last) discarding = 1'b0;
         return;
      end
      packet_len++;
      if (packet_len >= MAX_PACKET_DWORDS) begin
         outgoing_words.push_back('{32'h0, 1'b0, EV_OVERFLOW});
         packet_len = 0;
         discarding = !is_last;
         return;
      end
      // first two dwords wait for the third
      if (packet_len == 1) begin
         held_first = data;
      end else if (packet_len == 2) begin
         held_second = data;
      end else if (packet_len == MIN_DWORDS) begin
         outgoing_words.push_back('{held_first, 1'b0, EV_DWORD});
         outgoing_words.push_back('{held_second, 1'b0, EV_DWORD});
         outgoing_words.push_back('{data, is_last, EV_DWORD});
      end else begin
         outgoing_words.push_back('{data, is_last, EV_DWORD});
      end
      if (is_last) begin
         if (packet_len < MIN_DWORDS) outgoing_words.push_back('{32'h0, 1'b0, EV_SHORT});
         packet_len = 0;
      end
   endtask

   always @(posedge clock) begin
      tlp_word_type want;
      if (reset) begin
         packet_len  = 0;
         held_first  = '0;
         held_second = '0;
         discarding  = 1'b0;
         outgoing_words.delete();
      end else begin
         // compare before predicting: nothing leaves in the cycle it enters
         if (rsp_valid && rsp_ready) begin
            if (outgoing_words.size() == 0) begin
               report_mismatch($sformatf("unexpected word dword=%h last=%b ev=%0d",
                  rsp_tlp_dword, rsp_last_of_tlp, rsp_event_code));
            end else begin
               want = outgoing_words.pop_front();
               checked_count++;
               if (rsp_tlp_dword !== want.dword)
                  report_mismatch($sformatf("tlp_dword %h, wanted %h",
                     rsp_tlp_dword, want.dword));
               if (rsp_last_of_tlp !== want.last)
                  report_mismatch($sformatf("last_of_tlp %b, wanted %b",
                     rsp_last_of_tlp, want.last));
               if (rsp_event_code !== want.ev)
                  report_mismatch($sformatf("event_code %0d, wanted %0d",
                     rsp_event_code, want.ev));
            end
         end
         if (req_valid && req_ready) deframe_word(req_data_word, req_status_word);
      end
      pending_count = outgoing_words.size();
   end

endmodule

### tb/tb_tlp_rx_status_deframer.sv
`timescale 1ns / 100ps

module tb_tlp_rx_status_deframer;
   import tsd_pkg::*;

   localparam int CYCLE_LIMIT = 500000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_data_word = '0;
   logic [31:0] req_status_word = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_tlp_dword;
   logic        rsp_last_of_tlp;
   logic [1:0]  rsp_event_code;

   int fail_count;
   int pending_count;
   int checked_count;

   // pacing, in percent of cycles
   int send_idle = 0;
   int rsp_stall = 0;

   int cycle_count = 0;
   int words_sent = 0;
   int packets_sent = 0;
   int overflow_packets = 0;

   int idle_pct[4]  = '{0, 67, 0, 10};
   int stall_pct[4] = '{0, 0, 67, 10};
   // one packet runs past the size limit, in the last phase
   int long_len[4]  = '{0, 0, 0, MAX_PACKET_DWORDS + 3};

   tlp_rx_status_deframer i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_word   (req_data_word),
      .req_status_word (req_status_word),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_tlp_dword   (rsp_tlp_dword),
      .rsp_last_of_tlp (rsp_last_of_tlp),
      .rsp_event_code  (rsp_event_code)
   );

   tlp_rx_status_deframer_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_word   (req_data_word),
      .req_status_word (req_status_word),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_tlp_dword   (rsp_tlp_dword),
      .rsp_last_of_tlp (rsp_last_of_tlp),
      .rsp_event_code  (rsp_event_code),
      .fail_count      (fail_count),
      .pending_count   (pending_count),
      .checked_count   (checked_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall);
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timed out after %0d cycles, %0d words outstanding",
            cycle_count, pending_count);
         $display("TB_ERROR");
         $finish;
      end
   end

   // status patterns with random bits outside the compared fields
   function automatic logic [31:0] data_status();
      return PAT_DATA | ($urandom & ~MASK_LAST);
   endfunction

   function automatic logic [31:0] last_status();
      return PAT_LAST | ($urandom & ~MASK_LAST);
   endfunction

   // other traffic: half near misses with one pattern bit flipped
   function automatic logic [31:0] noise_status();
      logic [31:0] s;
      int          k;
      s = $urandom;
      if ($urandom_range(0, 1)) begin
         k = $urandom_range(0, 9);
         s = (s & ~MASK_DATA) | PAT_DATA;
         s = s ^ (32'h1 << (k < 8 ? 24 + k : 8 + k));
      end else if ((s & MASK_DATA) == PAT_DATA) begin
         s[31] = ~s[31];
      end
      return s;
   endfunction

   // present one link word and hold it until accepted; returns at a falling edge
   task automatic send_word(input logic [31:0] data, input logic [31:0] status);
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_data_word   <= data;
      req_status_word <= status;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // a packet of len dwords with random content and some other traffic mixed in
   task automatic send_packet(input int len, input bit closed, input int noise_pct);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 99) < noise_pct) send_word($urandom, noise_status());
         send_word($urandom, (closed && i == len - 1) ? last_status() : data_status());
      end
      words_sent += len;
      if (closed) packets_sent++;
      if (len >= MAX_PACKET_DWORDS) overflow_packets++;
   endtask

   initial begin
      int phase_words;
      int r;
      int len;

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: other traffic, short frames, minimum packet, field extremes
      send_word(32'hffff_ffff, 32'h0000_0000);
      send_word(32'h0000_0000, 32'hffff_ffff);
      send_word(32'h1234_5678, PAT_LAST ^ 32'h0100_0000);
      send_word(32'hffff_ffff, PAT_LAST | ~MASK_LAST);
      send_word(32'h0000_0000, PAT_DATA);
      send_word(32'hffff_ffff, PAT_LAST);
      send_word(32'hffff_ffff, PAT_DATA | ~MASK_LAST);
      send_word(32'h0000_0000, PAT_DATA);
      send_word(32'ha5a5_a5a5, PAT_LAST | ~MASK_LAST);
      // five dwords with other traffic between them
      send_word(32'h0000_0001, PAT_DATA);
      send_word(32'hdead_beef, 32'h7702_0000);
      send_word(32'h8000_0000, PAT_DATA);
      send_word(32'h7fff_ffff, PAT_DATA | 32'h00f8_ffff);
      send_word(32'hcafe_f00d, 32'hf707_0000);
      send_word(32'hffff_fffe, PAT_DATA);
      send_word(32'h0000_0000, PAT_LAST);
      words_sent += 11;
      packets_sent += 4;

      // four pacing phases of random traffic; the last one also overflows a packet
      for (int phase = 0; phase < 4; phase++) begin
         send_idle = idle_pct[phase];
         rsp_stall = stall_pct[phase];
         // a lone last word closes whatever came before
         send_packet(1, 1'b1, 0);
         if (long_len[phase] != 0) send_packet(long_len[phase], 1'b1, 5);
         phase_words = 0;
         while (phase_words < 24) begin
            r = $urandom_range(0, 99);
            len = (r < 70) ? $urandom_range(1, 6)
                : (r < 95) ? $urandom_range(7, 24) : $urandom_range(25, 60);
            send_packet(len, $urandom_range(0, 99) < 95, 10);
            phase_words += len;
         end
      end
      req_valid <= 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);

      $display("sent %0d packet dwords in %0d closed packets, %0d at or past the size limit,",
         words_sent, packets_sent, overflow_packets);
      $display("under four sender/receiver pacing mixes; %0d result words compared",
         checked_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
src/tsd_pkg.sv
src/tsd_front.sv
src/tsd_queue.sv
src/tsd_back.sv
src/tlp_rx_status_deframer.sv
tb/tlp_rx_status_deframer_checker.sv
tb/tb_tlp_rx_status_deframer.sv
